// ----- design/chs_pkg.sv -----
package chs_pkg;

    // angle inside the pipeline: 1/2^24 turn
    localparam int ANGLE_BITS = 24;
    localparam int HEAD_BITS = 16;
    localparam int DEG_BITS = 9;
    localparam int SECTOR_BITS = 5;
    localparam int TABLE_LEN = 24;
    localparam int SCALE_SHIFT = 16;
    localparam int GUARD_BITS = 2;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [ANGLE_BITS-1:0] ANGLE_ZERO = 24'h000000;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 24'h400000;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = 24'h800000;
    localparam logic [ANGLE_BITS-1:0] THREE_QUARTER_TURN = 24'hC00000;
    localparam logic [ANGLE_BITS-1:0] ROUND_HALF = 24'h000080;

    // declination after reset, about 0.22 rad
    localparam logic [HEAD_BITS-1:0] DECL_RESET = 16'd2295;

    localparam logic [8:0] DEG_PER_TURN = 9'd360;

    // sector bounds in 1/65536 turn, boundary value belongs to the lower sector
    localparam logic [HEAD_BITS-1:0] NORTH_LOW_BOUND = 16'd2048;
    localparam logic [HEAD_BITS-1:0] NORTH_HIGH_BOUND = 16'd63488;
    localparam logic [HEAD_BITS-1:0] SECTOR_ORIGIN = 16'd2049;
    localparam int SECTOR_SHIFT = 12;

    localparam logic [SECTOR_BITS-1:0] SECTOR_NNE = 5'd1;
    localparam logic [SECTOR_BITS-1:0] SECTOR_N = 5'd16;

    // angle word handed from cell to cell
    typedef struct packed {
        logic                  fixed;
        logic [ANGLE_BITS-1:0] z;
    } angle_t;

    // atan(2^-i) in 1/2^24 turn
    function automatic logic [ANGLE_BITS-1:0] atan_step(input int idx);
        logic [ANGLE_BITS-1:0] val;
        begin
            case (idx)
                0:       val = 24'd2097152;
                1:       val = 24'd1238021;
                2:       val = 24'd654136;
                3:       val = 24'd332050;
                4:       val = 24'd166669;
                5:       val = 24'd83416;
                6:       val = 24'd41718;
                7:       val = 24'd20860;
                8:       val = 24'd10430;
                9:       val = 24'd5215;
                10:      val = 24'd2608;
                11:      val = 24'd1304;
                12:      val = 24'd652;
                13:      val = 24'd326;
                14:      val = 24'd163;
                15:      val = 24'd81;
                16:      val = 24'd41;
                17:      val = 24'd20;
                18:      val = 24'd10;
                19:      val = 24'd5;
                20:      val = 24'd3;
                21:      val = 24'd1;
                22:      val = 24'd1;
                default: val = 24'd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ----- design/chs_prep.sv -----
module chs_prep #(
    parameter int SAMPLE_BITS = chs_pkg::SAMPLE_BITS_DEF,
    parameter int W = SAMPLE_BITS + chs_pkg::SCALE_SHIFT + chs_pkg::GUARD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic signed [SAMPLE_BITS-1:0] mag_x,
    input  logic signed [SAMPLE_BITS-1:0] mag_y,
    output logic                          down_valid,
    input  logic                          down_ready,
    output logic signed [W-1:0]           x_out,
    output logic signed [W-1:0]           y_out,
    output chs_pkg::angle_t               ang_out
);

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    chs_pkg::angle_t      ang_reg, ang_next;
    logic signed [W-1:0]  x_ext, y_ext;
    logic                 x_zero, y_zero;

    assign up_ready = !valid_reg || down_ready;

    // sign extend and scale by 2^16
    assign x_ext = {{(W - SAMPLE_BITS - chs_pkg::SCALE_SHIFT){mag_x[SAMPLE_BITS-1]}},
                    mag_x, {chs_pkg::SCALE_SHIFT{1'b0}}};
    assign y_ext = {{(W - SAMPLE_BITS - chs_pkg::SCALE_SHIFT){mag_y[SAMPLE_BITS-1]}},
                    mag_y, {chs_pkg::SCALE_SHIFT{1'b0}}};
    assign x_zero = (mag_x == '0);
    assign y_zero = (mag_y == '0);

    // axis and zero vectors get an exact angle, left half plane is turned over
    always_comb
    begin
        x_next = x_ext;
        y_next = y_ext;
        ang_next.fixed = 1'b1;
        ang_next.z = chs_pkg::ANGLE_ZERO;
        if (x_zero && y_zero)
        begin
            ang_next.z = chs_pkg::ANGLE_ZERO;
        end
        else if (y_zero)
        begin
            ang_next.z = mag_x[SAMPLE_BITS-1] ? chs_pkg::HALF_TURN : chs_pkg::ANGLE_ZERO;
        end
        else if (x_zero)
        begin
            ang_next.z = mag_y[SAMPLE_BITS-1] ? chs_pkg::THREE_QUARTER_TURN
                                              : chs_pkg::QUARTER_TURN;
        end
        else if (mag_x[SAMPLE_BITS-1])
        begin
            ang_next.fixed = 1'b0;
            x_next = -x_ext;
            y_next = -y_ext;
            ang_next.z = chs_pkg::HALF_TURN;
        end
        else
        begin
            ang_next.fixed = 1'b0;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign down_valid = valid_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign ang_out = ang_reg;

endmodule

// ----- design/chs_cell.sv -----
module chs_cell #(
    parameter int W = chs_pkg::SAMPLE_BITS_DEF + chs_pkg::SCALE_SHIFT + chs_pkg::GUARD_BITS,
    parameter int SHIFT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    input  chs_pkg::angle_t     ang_in,
    output logic                down_valid,
    input  logic                down_ready,
    output logic signed [W-1:0] x_out,
    output logic signed [W-1:0] y_out,
    output chs_pkg::angle_t     ang_out
);

    localparam logic [chs_pkg::ANGLE_BITS-1:0] ATAN_VAL = chs_pkg::atan_step(SHIFT);

    logic                valid_reg;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    chs_pkg::angle_t     ang_reg, ang_next;
    logic signed [W-1:0] dx, dy;

    assign up_ready = !valid_reg || down_ready;
    assign dx = y_in >>> SHIFT;
    assign dy = x_in >>> SHIFT;

    // one vectoring rotation toward the x axis
    always_comb
    begin
        x_next = x_in;
        y_next = y_in;
        ang_next = ang_in;
        if (!ang_in.fixed)
        begin
            if (!y_in[W-1])
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                ang_next.z = ang_in.z + ATAN_VAL;
            end
            else
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                ang_next.z = ang_in.z - ATAN_VAL;
            end
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign down_valid = valid_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign ang_out = ang_reg;

endmodule

// ----- design/chs_finish.sv -----
module chs_finish (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  chs_pkg::angle_t                       ang_in,
    input  logic [chs_pkg::HEAD_BITS-1:0]         decl,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [chs_pkg::HEAD_BITS-1:0]         heading_turns,
    output logic [chs_pkg::DEG_BITS-1:0]          heading_degrees,
    output logic [chs_pkg::SECTOR_BITS-1:0]       sector
);

    localparam int PROD_BITS = chs_pkg::HEAD_BITS + chs_pkg::DEG_BITS;

    logic                                 head_valid_reg;
    logic                                 head_ready;
    logic [chs_pkg::HEAD_BITS-1:0]        head_reg, head_next;
    logic [chs_pkg::ANGLE_BITS-1:0]       z_round;

    logic                                 out_valid_reg;
    logic [chs_pkg::HEAD_BITS-1:0]        turns_reg;
    logic [chs_pkg::DEG_BITS-1:0]         deg_reg, deg_next;
    logic [chs_pkg::SECTOR_BITS-1:0]      sector_reg, sector_next;
    logic [PROD_BITS-1:0]                 deg_prod;
    logic [chs_pkg::HEAD_BITS-1:0]        sector_offs;

    // round to 1/65536 turn and add declination, wrapping in one turn
    assign z_round = ang_in.z + chs_pkg::ROUND_HALF;
    assign head_next = z_round[chs_pkg::ANGLE_BITS-1 -: chs_pkg::HEAD_BITS] + decl;

    assign up_ready = !head_valid_reg || head_ready;
    assign head_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_valid_reg <= 1'b0;
        else if (up_ready)
            head_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            head_reg <= head_next;
    end

    // whole degrees and compass point
    assign deg_prod = PROD_BITS'(head_reg) * PROD_BITS'(chs_pkg::DEG_PER_TURN);
    assign deg_next = deg_prod[PROD_BITS-1 -: chs_pkg::DEG_BITS];
    assign sector_offs = head_reg - chs_pkg::SECTOR_ORIGIN;

    always_comb
    begin
        if (head_reg <= chs_pkg::NORTH_LOW_BOUND || head_reg > chs_pkg::NORTH_HIGH_BOUND)
            sector_next = chs_pkg::SECTOR_N;
        else
            sector_next = chs_pkg::SECTOR_BITS'(sector_offs >> chs_pkg::SECTOR_SHIFT)
                          + chs_pkg::SECTOR_NNE;
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (head_ready)
            out_valid_reg <= head_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (head_ready && head_valid_reg)
        begin
            turns_reg <= head_reg;
            deg_reg <= deg_next;
            sector_reg <= sector_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign heading_turns = turns_reg;
    assign heading_degrees = deg_reg;
    assign sector = sector_reg;

endmodule

// ----- design/compass_heading_sector_top.sv -----
// register path: prep stage, each CORDIC cell, then the heading and output registers in the finish stage
// throughput: one word per cycle while the output is not stalled, one CORDIC rotation per cell in the chain
// a stalled output stops the chain only once bubbles between the cells are filled
// reset: stage valid bits clear, declination returns to 2295
// no memories, so no clearing pass after reset
module compass_heading_sector_top #(
    parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS = chs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic signed [chs_pkg::HEAD_BITS-1:0]  declination,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         mag_x,
    input  logic signed [SAMPLE_BITS-1:0]         mag_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [chs_pkg::HEAD_BITS-1:0]         heading_turns,
    output logic [chs_pkg::DEG_BITS-1:0]          heading_degrees,
    output logic [chs_pkg::SECTOR_BITS-1:0]       sector
);

    localparam int W = SAMPLE_BITS + chs_pkg::SCALE_SHIFT + chs_pkg::GUARD_BITS;

    logic [chs_pkg::HEAD_BITS-1:0] decl_reg;

    logic                valid_chain [0:CORDIC_STEPS];
    logic                ready_chain [0:CORDIC_STEPS];
    logic signed [W-1:0] x_chain     [0:CORDIC_STEPS];
    logic signed [W-1:0] y_chain     [0:CORDIC_STEPS];
    chs_pkg::angle_t     ang_chain   [0:CORDIC_STEPS];

    // declination register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decl_reg <= chs_pkg::DECL_RESET;
        else if (cfg_valid && cfg_ready)
            decl_reg <= declination;
    end

    // scaling and half-plane fold
    chs_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .W           (W)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .down_valid (valid_chain[0]),
        .down_ready (ready_chain[0]),
        .x_out      (x_chain[0]),
        .y_out      (y_chain[0]),
        .ang_out    (ang_chain[0])
    );

    // chain of rotation cells
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        chs_cell #(
            .W     (W),
            .SHIFT (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (valid_chain[i]),
            .up_ready   (ready_chain[i]),
            .x_in       (x_chain[i]),
            .y_in       (y_chain[i]),
            .ang_in     (ang_chain[i]),
            .down_valid (valid_chain[i+1]),
            .down_ready (ready_chain[i+1]),
            .x_out      (x_chain[i+1]),
            .y_out      (y_chain[i+1]),
            .ang_out    (ang_chain[i+1])
        );
    end

    // rounding, declination, degrees and sector
    chs_finish u_finish (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_valid        (valid_chain[CORDIC_STEPS]),
        .up_ready        (ready_chain[CORDIC_STEPS]),
        .ang_in          (ang_chain[CORDIC_STEPS]),
        .decl            (decl_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .heading_turns   (heading_turns),
        .heading_degrees (heading_degrees),
        .sector          (sector)
    );

    // output word consistency
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sector >= chs_pkg::SECTOR_NNE && sector <= chs_pkg::SECTOR_N))
        else $error("sector out of range");

    a_degree_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_degrees < chs_pkg::DEG_PER_TURN))
        else $error("degrees out of range");

    a_north_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && heading_turns <= chs_pkg::NORTH_LOW_BOUND) |-> (sector == chs_pkg::SECTOR_N))
        else $error("heading near zero not north");

    a_north_high: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && heading_turns > chs_pkg::NORTH_HIGH_BOUND) |-> (sector == chs_pkg::SECTOR_N))
        else $error("heading near full turn not north");

endmodule
